// ===== design/utf8_text_cell_layout_macros.svh =====
// Assertion macros for the text cell layout block.
`ifndef UTF8_TEXT_CELL_LAYOUT_MACROS_SVH
`define UTF8_TEXT_CELL_LAYOUT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UTCL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utcl assertion failed");
`define UTCL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utcl assertion failed");
`else
`define UTCL_ASSERT_IMP(label, ante, cons)
`define UTCL_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== design/utcl_pkg.sv =====
// Shared types, constants, a font table and lookup functions.
`default_nettype none
package utcl_pkg;

	localparam int COLS = 21;
	localparam int ROWS = 8;
	localparam int LA = COLS + 1;
	localparam int WC_W = $clog2(LA + 1);
	localparam int WI_W = $clog2(LA);
	localparam int COL_W = 5;
	localparam int ROW_W = 4;
	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_AW = 2;
	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_AW = 1;
	localparam int GLYPHS = 139;
	localparam logic [7:0] QMARK_IDX = 8'd31;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_CELL  = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		EV_BEGIN,
		EV_CHAR,
		EV_NUL,
		EV_END,
		EV_DONE
	} ev_op_t;

	typedef enum logic [1:0] {
		CH_GLYPH,
		CH_SPACE,
		CH_NEWLINE
	} ch_cls_t;

	typedef struct packed {
		ev_op_t     op;
		ch_cls_t    cls;
		logic [7:0] glyph;
		logic [1:0] used_m1;
	} ev_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  row;
		logic [4:0]  col;
		logic [39:0] px;
		logic [15:0] bytes;
		logic        last;
	} res_t;

	// five pixel columns per glyph, column 0 in the top byte
	localparam logic [39:0] GLYPH_ROM [0:GLYPHS-1] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
		40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
		40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
		40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
		40'h00007F0000, 40'h0041360800, 40'h0201020402,
		40'h2055565478, 40'h2056555678, 40'h2056545678, 40'h3844C4C420,
		40'h3855565418, 40'h3854565518, 40'h3856555618, 40'h3856545618,
		40'h00467D4200, 40'h00457C4100, 40'h3846454638, 40'h3846444638,
		40'h3C4142207C, 40'h3C4241227C, 40'h3C4240227C, 40'h0C5250523C,
		40'h38447C5418, 40'hFC232322FC, 40'hFC232323FC, 40'hFC232223FC,
		40'h3E41C1C122, 40'hFE93939282, 40'hFE92939382, 40'hFE93939382,
		40'hFE93929382, 40'h0083FF8300, 40'h0083FE8300, 40'h7C8383837C,
		40'h7C8382837C, 40'h7E8181807E, 40'h7E8181817E, 40'h7E8180817E,
		40'h7C82FE9282, 40'h0008142241, 40'h4122140800, 40'h0006090906,
		40'h0003050000, 40'h0005030000, 40'h0007000700, 40'h0007000700,
		40'h0808080808, 40'h0808080808, 40'h4000400040, 40'h143E554122
	};

	function automatic logic [39:0] glyph_px(input logic [7:0] idx);
		logic [39:0] px;
		if (idx < 8'(GLYPHS))
			px = GLYPH_ROM[idx];
		else
			px = GLYPH_ROM[QMARK_IDX];
		return px;
	endfunction

	function automatic logic [7:0] cp_glyph(input logic [20:0] cp);
		logic [7:0] g;
		if (cp >= 21'h20 && cp <= 21'h7E) begin
			g = 8'(cp - 21'h20);
		end else begin
			case (cp)
				21'h00E0: g = 8'd95;
				21'h00E2: g = 8'd96;
				21'h00E4: g = 8'd97;
				21'h00E7: g = 8'd98;
				21'h00E8: g = 8'd99;
				21'h00E9: g = 8'd100;
				21'h00EA: g = 8'd101;
				21'h00EB: g = 8'd102;
				21'h00EE: g = 8'd103;
				21'h00EF: g = 8'd104;
				21'h00F4: g = 8'd105;
				21'h00F6: g = 8'd106;
				21'h00F9: g = 8'd107;
				21'h00FB: g = 8'd108;
				21'h00FC: g = 8'd109;
				21'h00FF: g = 8'd110;
				21'h0153: g = 8'd111;
				21'h00C0: g = 8'd112;
				21'h00C2: g = 8'd113;
				21'h00C4: g = 8'd114;
				21'h00C7: g = 8'd115;
				21'h00C8: g = 8'd116;
				21'h00C9: g = 8'd117;
				21'h00CA: g = 8'd118;
				21'h00CB: g = 8'd119;
				21'h00CE: g = 8'd120;
				21'h00CF: g = 8'd121;
				21'h00D4: g = 8'd122;
				21'h00D6: g = 8'd123;
				21'h00D9: g = 8'd124;
				21'h00DB: g = 8'd125;
				21'h00DC: g = 8'd126;
				21'h0152: g = 8'd127;
				21'h00AB: g = 8'd128;
				21'h00BB: g = 8'd129;
				21'h00B0: g = 8'd130;
				21'h2018: g = 8'd131;
				21'h2019: g = 8'd132;
				21'h201C: g = 8'd133;
				21'h201D: g = 8'd134;
				21'h2013: g = 8'd135;
				21'h2014: g = 8'd136;
				21'h2026: g = 8'd137;
				21'h20AC: g = 8'd138;
				default:  g = QMARK_IDX;
			endcase
		end
		return g;
	endfunction

endpackage
`default_nettype wire

// ===== design/utcl_front.sv =====
// Front end: byte intake and UTF-8 decoding into layout events.
`default_nettype none
module utcl_front import utcl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] text_byte,
	input  wire logic       page_begin,
	input  wire logic       text_end,
	input  wire logic       push,
	output logic            full,
	output ev_t             ev,
	output logic            ev_push,
	input  wire logic       ev_full
);

	logic [7:0]  sb_q [4];
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        begin_q;
	logic        end_q;
	logic        endsent_q;

	logic [7:0]  b0;
	logic [2:0]  need;
	logic        broken;
	logic        hold;
	logic        dec_go;
	logic        is_nul;
	logic [20:0] cp;
	logic [2:0]  used;
	logic        accept;
	logic        step;

	assign full   = busy_q;
	assign accept = push && !busy_q;
	assign step   = busy_q && !ev_full;

	always_comb begin
		b0 = sb_q[0];
		if (b0[7:5] == 3'b110)
			need = 3'd2;
		else if (b0[7:4] == 4'b1110)
			need = 3'd3;
		else if (b0[7:3] == 5'b11110)
			need = 3'd4;
		else
			need = 3'd0;
		broken = 1'b0;
		for (int i = 1; i < 4; i++) begin
			if (3'(i) < need && 3'(i) < cnt_q && sb_q[i][7:6] != 2'b10)
				broken = 1'b1;
		end
		// incomplete sequence waits for more bytes unless the text ends here
		hold   = (need != 3'd0) && !broken && (cnt_q < need) && !end_q;
		dec_go = (cnt_q != 3'd0) && !hold;
		is_nul = (b0 == 8'h00);
		cp     = 21'h3F;
		used   = 3'd1;
		if (!b0[7]) begin
			cp = {13'd0, b0};
		end else if (need != 3'd0 && !broken && cnt_q >= need) begin
			used = need;
			case (need)
				3'd2:    cp = {10'd0, b0[4:0], sb_q[1][5:0]};
				3'd3:    cp = {5'd0, b0[3:0], sb_q[1][5:0], sb_q[2][5:0]};
				default: cp = {b0[2:0], sb_q[1][5:0], sb_q[2][5:0], sb_q[3][5:0]};
			endcase
		end
	end

	always_comb begin
		ev      = '0;
		ev_push = step;
		if (begin_q) begin
			ev.op = EV_BEGIN;
		end else if (dec_go) begin
			ev.op      = is_nul ? EV_NUL : EV_CHAR;
			ev.used_m1 = 2'(used - 3'd1);
			ev.glyph   = cp_glyph(cp);
			if (cp == 21'h0A)
				ev.cls = CH_NEWLINE;
			else if (cp == 21'h20 || cp == 21'hA0)
				ev.cls = CH_SPACE;
			else
				ev.cls = CH_GLYPH;
		end else if (end_q && !endsent_q) begin
			ev.op = EV_END;
		end else begin
			ev.op = EV_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			begin_q   <= 1'b0;
			end_q     <= 1'b0;
			endsent_q <= 1'b0;
		end else if (accept) begin
			busy_q    <= 1'b1;
			begin_q   <= page_begin;
			end_q     <= text_end;
			endsent_q <= 1'b0;
			cnt_q     <= page_begin ? 3'd1 : cnt_q + 3'd1;
		end else if (step) begin
			if (begin_q)
				begin_q <= 1'b0;
			else if (dec_go)
				cnt_q <= is_nul ? 3'd0 : cnt_q - used;
			else if (end_q && !endsent_q) begin
				endsent_q <= 1'b1;
				cnt_q     <= '0;
			end else
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (page_begin)
				sb_q[0] <= text_byte;
			else
				sb_q[cnt_q[1:0]] <= text_byte;
		end else if (step && !begin_q && dec_go && !is_nul) begin
			for (int k = 0; k < 4; k++) begin
				if (k + int'(used) < 4)
					sb_q[k] <= sb_q[k + int'(used)];
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/utcl_evq.sv =====
// Event queue between the decoder and the layout engine.
`default_nettype none
module utcl_evq import utcl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  ev_t       wr_data,
	input  wire logic wr_en,
	output logic      full,
	output ev_t       rd_data,
	input  wire logic rd_en,
	output logic      empty
);

	ev_t               mem_q [EVQ_DEPTH];
	logic [EVQ_AW-1:0] wp_q;
	logic [EVQ_AW-1:0] rp_q;
	logic [EVQ_AW:0]   cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (cnt_q == (EVQ_AW+1)'(EVQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + 1'b1;
			if (do_rd)
				rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wr_data;
	end

endmodule
`default_nettype wire

// ===== design/utcl_back.sv =====
// Layout engine: word lookahead buffer, wrap test, cursor and byte count.
`default_nettype none
module utcl_back import utcl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  ev_t       ev,
	input  wire logic ev_valid,
	output logic      ev_pop,
	output res_t      res,
	output logic      res_push,
	input  wire logic res_full
);

	logic [COL_W-1:0] col_q, col_n;
	logic [ROW_W-1:0] row_q, row_n;
	logic [WC_W-1:0]  wc_q, wc_n;
	logic [15:0]      comm_q, comm_n;
	logic             pf_q, pf_n;
	logic [7:0]       widx_q [LA];
	logic [1:0]       wby_q [LA];
	res_t             pend_q;
	logic             pend_v_q;

	logic             go;
	logic             place;
	logic             wr_word;
	logic             emit_v;
	res_t             emit_r;
	logic             fin;
	logic             brk;
	logic             last_row;
	logic [6:0]       span;
	logic [2:0]       add;
	logic [16:0]      sum;
	logic [16:0]      head_sum;

	assign go       = !res_full;
	assign span     = 7'(col_q) + 7'(wc_q);
	assign brk      = (col_q != '0 && span > 7'(COLS) && wc_q <= WC_W'(COLS))
	                  || col_q >= COL_W'(COLS);
	assign last_row = (5'(row_q) + 5'd1) >= 5'(ROWS);
	assign head_sum = {1'b0, comm_q} + 17'(wby_q[0]) + 17'd1;
	assign sum      = {1'b0, comm_q} + 17'(add);

	always_comb begin
		col_n   = col_q;
		row_n   = row_q;
		wc_n    = wc_q;
		comm_n  = comm_q;
		pf_n    = pf_q;
		place   = 1'b0;
		wr_word = 1'b0;
		emit_v  = 1'b0;
		emit_r  = '0;
		fin     = 1'b0;
		ev_pop  = 1'b0;
		add     = {1'b0, ev.used_m1} + 3'd1;
		if (go) begin
			// a full lookahead places its head before anything else
			if (!pf_q && wc_q == WC_W'(LA)) begin
				place = 1'b1;
			end else if (ev_valid) begin
				unique case (ev.op)
					EV_BEGIN: begin
						col_n       = '0;
						row_n       = '0;
						wc_n        = '0;
						comm_n      = '0;
						pf_n        = 1'b0;
						emit_v      = 1'b1;
						emit_r.kind = KIND_CLEAR;
						ev_pop      = 1'b1;
					end
					EV_CHAR: begin
						if (pf_q) begin
							ev_pop = 1'b1;
						end else if (ev.cls == CH_GLYPH) begin
							wr_word = 1'b1;
							wc_n    = wc_q + 1'b1;
							ev_pop  = 1'b1;
						end else if (wc_q != '0) begin
							place = 1'b1;
						end else begin
							ev_pop = 1'b1;
							comm_n = sum[16] ? 16'hFFFF : sum[15:0];
							if (ev.cls == CH_SPACE) begin
								if (col_q != '0 && col_q < COL_W'(COLS)) begin
									emit_v      = 1'b1;
									emit_r.kind = KIND_CELL;
									emit_r.row  = row_q[2:0];
									emit_r.col  = col_q;
									col_n       = col_q + 1'b1;
								end
							end else begin
								col_n = '0;
								if (last_row) begin
									pf_n = 1'b1;
									wc_n = '0;
								end else begin
									row_n = row_q + 1'b1;
								end
							end
						end
					end
					EV_NUL: begin
						if (pf_q) begin
							ev_pop = 1'b1;
						end else if (wc_q != '0) begin
							place = 1'b1;
						end else begin
							pf_n   = 1'b1;
							ev_pop = 1'b1;
						end
					end
					EV_END: begin
						if (!pf_q && wc_q != '0) begin
							place = 1'b1;
						end else begin
							emit_v       = 1'b1;
							emit_r.kind  = KIND_DONE;
							emit_r.bytes = comm_q;
							col_n        = '0;
							row_n        = '0;
							wc_n         = '0;
							comm_n       = '0;
							pf_n         = 1'b0;
							ev_pop       = 1'b1;
						end
					end
					EV_DONE: begin
						fin    = 1'b1;
						ev_pop = 1'b1;
					end
					default: ev_pop = 1'b1;
				endcase
			end
		end
		if (place) begin
			wc_n = wc_q - 1'b1;
			if (brk && last_row) begin
				pf_n  = 1'b1;
				wc_n  = '0;
				col_n = '0;
			end else begin
				row_n       = brk ? row_q + 1'b1 : row_q;
				col_n       = (brk ? COL_W'(0) : col_q) + 1'b1;
				emit_v      = 1'b1;
				emit_r.kind = KIND_CELL;
				emit_r.row  = brk ? 3'(row_q + 1'b1) : row_q[2:0];
				emit_r.col  = brk ? COL_W'(0) : col_q;
				emit_r.px   = glyph_px(widx_q[0]);
				comm_n      = head_sum[16] ? 16'hFFFF : head_sum[15:0];
			end
		end
	end

	// the newest result is held back until it is known whether it closes its run
	always_comb begin
		res      = pend_q;
		res.last = fin;
		res_push = pend_v_q && (emit_v || fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			wc_q     <= '0;
			comm_q   <= '0;
			pf_q     <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			col_q  <= col_n;
			row_q  <= row_n;
			wc_q   <= wc_n;
			comm_q <= comm_n;
			pf_q   <= pf_n;
			if (emit_v)
				pend_v_q <= 1'b1;
			else if (fin)
				pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v)
			pend_q <= emit_r;
		if (place) begin
			for (int i = 0; i < LA - 1; i++) begin
				widx_q[i] <= widx_q[i + 1];
				wby_q[i]  <= wby_q[i + 1];
			end
		end else if (wr_word) begin
			widx_q[wc_q[WI_W-1:0]] <= ev.glyph;
			wby_q[wc_q[WI_W-1:0]]  <= ev.used_m1;
		end
	end

endmodule
`default_nettype wire

// ===== design/utcl_resq.sv =====
// Result queue that drives the output side.
`default_nettype none
module utcl_resq import utcl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  res_t      wr_data,
	input  wire logic wr_en,
	output logic      full,
	output res_t      rd_data,
	input  wire logic rd_en,
	output logic      empty
);

	res_t               mem_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0] wp_q;
	logic [RESQ_AW-1:0] rp_q;
	logic [RESQ_AW:0]   cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (cnt_q == (RESQ_AW+1)'(RESQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + 1'b1;
			if (do_rd)
				rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wr_data;
	end

endmodule
`default_nettype wire

// ===== design/utf8_text_cell_layout.sv =====
// Top level: UTF-8 text page to glyph cell layout with greedy word wrap.
//
//  channel   handshake     direction  payload
//  text in   push / full   in         text_byte, page_begin, text_end
//  results   pop / empty   out        item_kind, cell_row, cell_col, glyph_col0..4,
//                                     bytes_consumed, last_of_run
//
// A byte is taken while full is low; the decoder then emits each event it makes
// (frame clear, each character, end, run close), waiting while the event queue is
// full; full stays high meanwhile. The layout engine places one buffered glyph per
// cycle unless the result queue is full; the event queue lets the decoder run ahead.
// Reset is asynchronous and clears all control state; no clearing pass.
// Either side may stall at any time; a full result queue stalls the layout.
`default_nettype none
`include "utf8_text_cell_layout_macros.svh"
module utf8_text_cell_layout import utcl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  text_byte,
	input  wire logic        page_begin,
	input  wire logic        text_end,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       item_kind,
	output logic [2:0]       cell_row,
	output logic [4:0]       cell_col,
	output logic [7:0]       glyph_col0,
	output logic [7:0]       glyph_col1,
	output logic [7:0]       glyph_col2,
	output logic [7:0]       glyph_col3,
	output logic [7:0]       glyph_col4,
	output logic [15:0]      bytes_consumed,
	output logic             last_of_run
);

	ev_t  fe_ev;
	logic fe_push;
	logic evq_full;
	ev_t  evq_data;
	logic evq_empty;
	logic be_pop;
	res_t be_res;
	logic be_push;
	logic resq_full;
	res_t head;

	utcl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.page_begin (page_begin),
		.text_end   (text_end),
		.push       (push),
		.full       (full),
		.ev         (fe_ev),
		.ev_push    (fe_push),
		.ev_full    (evq_full)
	);

	utcl_evq u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (fe_ev),
		.wr_en   (fe_push),
		.full    (evq_full),
		.rd_data (evq_data),
		.rd_en   (be_pop),
		.empty   (evq_empty)
	);

	utcl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev       (evq_data),
		.ev_valid (!evq_empty),
		.ev_pop   (be_pop),
		.res      (be_res),
		.res_push (be_push),
		.res_full (resq_full)
	);

	utcl_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (be_res),
		.wr_en   (be_push),
		.full    (resq_full),
		.rd_data (head),
		.rd_en   (pop),
		.empty   (empty)
	);

	assign item_kind      = head.kind;
	assign cell_row       = head.row;
	assign cell_col       = head.col;
	assign glyph_col0     = head.px[39:32];
	assign glyph_col1     = head.px[31:24];
	assign glyph_col2     = head.px[23:16];
	assign glyph_col3     = head.px[15:8];
	assign glyph_col4     = head.px[7:0];
	assign bytes_consumed = head.bytes;
	assign last_of_run    = head.last;

	`UTCL_ASSERT_NXT(a_busy_after_take, push && !full, full)
	`UTCL_ASSERT_IMP(a_done_closes_run, !empty && item_kind == KIND_DONE, last_of_run)
	`UTCL_ASSERT_IMP(a_cell_in_line, !empty && item_kind == KIND_CELL, cell_col < 5'(COLS))
	`UTCL_ASSERT_IMP(a_clear_no_count, !empty && item_kind == KIND_CLEAR, bytes_consumed == 16'd0)

endmodule
`default_nettype wire
